// ===== hdl/npf_pkg.sv =====
// Package for the neighbor pair filter: payload structs, register indexes,
// defaults and the config record passed from the top level to the back part.
package npf_pkg;

  localparam int INDEX_BITS_DEF = 20;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_ADDR_BITS-1:0] REG_LIST_MODE = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SIZE_MODE = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HISTORY   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OWNED     = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SKIN      = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TIE_DELTA = 3'd5;

  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_HALF  = 2'd1;
  localparam logic [1:0] MODE_ORTHO = 2'd2;
  localparam logic [1:0] MODE_TRI   = 2'd3;

  localparam logic [30:0] TIE_DELTA_RESET = 31'd655;

  localparam logic FUNC_LOAD = 1'b0;

  typedef struct packed {
    logic        func;
    logic [INDEX_BITS_DEF-1:0] atom_index;
    logic [30:0] atom_tag;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0] atom_radius;
    logic [62:0] cutoff_sq;
    logic        first_bin;
    logic        same_group;
    logic        same_size;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS_DEF-1:0] neighbor_index;
    logic                      touching;
  } out_item_t;

  // Queue entry: the classified candidate with the distance inputs.
  typedef struct packed {
    logic [INDEX_BITS_DEF-1:0] index;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] dz;
    logic [31:0] radsum;
    logic [62:0] cutoff_sq;
  } work_t;

  typedef struct packed {
    logic        size_mode;
    logic        history_on;
    logic [30:0] skin;
  } back_cfg_t;

endpackage

// ===== hdl/neighbor_pair_filter.sv =====
// Neighbor pair filter top level: one item per cycle; results pass through the
// queue entry, then the squares, sum and compare registers.
// The input stalls only when the queue (two entries by default) is full,
// which the output stall causes.
// Synchronous active-low reset zeroes the control registers, tie_delta to 655.
// Depends on npf_pkg, npf_front, npf_queue, npf_back.
module neighbor_pair_filter #(
  parameter int QUEUE_DEPTH = npf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  npf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output npf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [npf_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [npf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic [1:0] list_mode_r;
  logic size_mode_r, history_r;
  logic [20:0] owned_r;
  logic [30:0] skin_r, tie_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_mode_r <= '0; size_mode_r <= 1'b0; history_r <= 1'b0;
      owned_r <= '0; skin_r <= '0; tie_r <= npf_pkg::TIE_DELTA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        npf_pkg::REG_LIST_MODE: list_mode_r <= cfg_data[1:0];
        npf_pkg::REG_SIZE_MODE: size_mode_r <= cfg_data[0];
        npf_pkg::REG_HISTORY:   history_r <= cfg_data[0];
        npf_pkg::REG_OWNED:     owned_r <= cfg_data[20:0];
        npf_pkg::REG_SKIN:      skin_r <= cfg_data[30:0];
        npf_pkg::REG_TIE_DELTA: tie_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic fire, keep, q_full, q_ne, q_pop;
  npf_pkg::work_t fw, qd;
  npf_pkg::back_cfg_t bcfg;

  assign in_stall = q_full;
  assign fire = in_valid && !q_full;

  npf_front u_front (
    .clk, .rst_n, .fire, .item(in_data), .list_mode(list_mode_r),
    .owned_count(owned_r), .tie_delta(tie_r), .keep, .work(fw)
  );

  npf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(fire && keep), .push_data(fw), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(qd)
  );

  assign bcfg = '{size_mode: size_mode_r, history_on: history_r, skin: skin_r};

  npf_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_data(qd), .q_pop, .cfg(bcfg),
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== hdl/npf_front.sv =====
// Front part: holds the center atom and applies list-mode ownership rules.
// Depends on npf_pkg.
module npf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  npf_pkg::in_item_t item,
  input  logic [1:0]        list_mode,
  input  logic [20:0]       owned_count,
  input  logic [30:0]       tie_delta,
  output logic              keep,
  output npf_pkg::work_t    work
);

  localparam int INDEX_BITS = npf_pkg::INDEX_BITS_DEF;

  logic [INDEX_BITS-1:0] cidx_r;
  logic [30:0] ctag_r, crad_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cidx_r <= '0; ctag_r <= '0; crad_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
    end else if (fire && item.func == npf_pkg::FUNC_LOAD) begin
      cidx_r <= item.atom_index[INDEX_BITS-1:0];
      ctag_r <= item.atom_tag;
      crad_r <= item.atom_radius;
      cx_r <= item.pos_x; cy_r <= item.pos_y; cz_r <= item.pos_z;
    end
  end

  logic [INDEX_BITS-1:0] idx;
  logic ghost, odd;
  logic signed [32:0] dx, dy, dz;
  logic [32:0] adz, ady;

  assign idx = item.atom_index[INDEX_BITS-1:0];
  assign ghost = {1'b0, idx} >= owned_count;
  assign odd = ctag_r[0] ^ item.atom_tag[0];
  assign dx = 33'(item.pos_x) - 33'(cx_r);
  assign dy = 33'(item.pos_y) - 33'(cy_r);
  assign dz = 33'(item.pos_z) - 33'(cz_r);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  always_comb begin
    keep = (item.func != npf_pkg::FUNC_LOAD);
    case (list_mode)
      npf_pkg::MODE_FULL: begin
        if (idx == cidx_r) keep = 1'b0;
      end
      npf_pkg::MODE_HALF: begin
        if (idx <= cidx_r) keep = 1'b0;
      end
      npf_pkg::MODE_ORTHO: begin
        if (item.first_bin && item.same_size) begin
          if (!item.same_group && idx < cidx_r) keep = 1'b0;
          if (ghost) begin
            if (item.pos_z < cz_r) keep = 1'b0;
            else if (item.pos_z == cz_r) begin
              if (item.pos_y < cy_r) keep = 1'b0;
              else if (item.pos_y == cy_r && item.pos_x < cx_r) keep = 1'b0;
            end
          end
        end
      end
      default: begin
        if (item.same_size) begin
          if (idx <= cidx_r) keep = 1'b0;
          else if (ghost) begin
            if (ctag_r > item.atom_tag) begin
              if (!odd) keep = 1'b0;
            end else if (ctag_r < item.atom_tag) begin
              if (odd) keep = 1'b0;
            end else if (adz > {2'b0, tie_delta}) begin
              if (item.pos_z < cz_r) keep = 1'b0;
            end else if (ady > {2'b0, tie_delta}) begin
              if (item.pos_y < cy_r) keep = 1'b0;
            end else if (item.pos_x < cx_r) keep = 1'b0;
          end
        end
      end
    endcase
  end

  always_comb begin
    work = '0;
    work.index = idx;
    work.dx = dx[32] ? 33'(-dx) : 33'(dx);
    work.dy = ady;
    work.dz = adz;
    work.radsum = 32'(crad_r) + 32'(item.atom_radius);
    work.cutoff_sq = item.cutoff_sq;
  end

endmodule

// ===== hdl/npf_queue.sv =====
// Short queue between the front and back parts.
// Depends on npf_pkg.
module npf_queue #(
  parameter int DEPTH = npf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  npf_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output npf_pkg::work_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  npf_pkg::work_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  assign full = (cnt_r == (PW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ===== hdl/npf_back.sv =====
// Back part: squares, sum and cutoff compare in three stages, then output.
// Depends on npf_pkg.
module npf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  npf_pkg::work_t     q_data,
  output logic               q_pop,
  input  npf_pkg::back_cfg_t cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output npf_pkg::out_item_t out_data
);

  localparam int INDEX_BITS = npf_pkg::INDEX_BITS_DEF;

  // stage 1: squares
  logic s1_v_r, s2_v_r, o_v_r;
  logic [65:0] sx_r, sy_r, sz_r, lim_r, tch_r;
  logic [INDEX_BITS-1:0] i1_r, i2_r;
  logic [62:0] cut1_r;
  // stage 2: sum
  logic [67:0] rsq_r;
  logic [67:0] lim2_r, tch2_r;
  logic en;

  logic [32:0] lsum;
  assign lsum = 33'(q_data.radsum) + 33'(cfg.skin);

  // The pipeline moves as a whole; it stops only when the output is held.
  assign en = !(o_v_r && out_stall);
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; o_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
      o_v_r <= s2_v_r && (rsq_r <= lim2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= 66'(q_data.dx) * 66'(q_data.dx);
      sy_r <= 66'(q_data.dy) * 66'(q_data.dy);
      sz_r <= 66'(q_data.dz) * 66'(q_data.dz);
      lim_r <= 66'(lsum) * 66'(lsum);
      tch_r <= 66'(q_data.radsum) * 66'(q_data.radsum);
      i1_r <= q_data.index[INDEX_BITS-1:0];
      cut1_r <= q_data.cutoff_sq;
      rsq_r <= 68'(sx_r) + 68'(sy_r) + 68'(sz_r);
      lim2_r <= cfg.size_mode ? 68'(lim_r) : 68'(cut1_r);
      tch2_r <= 68'(tch_r);
      i2_r <= i1_r;
      out_data.neighbor_index <= i2_r;
      out_data.touching <= cfg.size_mode && cfg.history_on && (rsq_r < tch2_r);
    end
  end

  assign out_valid = o_v_r;

endmodule

// ===== hdl/npf_checker.sv =====
// Port-level checks for the neighbor pair filter, bound to the top level.
// Depends on npf_pkg.
module npf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input npf_pkg::out_item_t out_data,
  input logic               cfg_ready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> !in_stall)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk) cfg_ready)
    else $error("config port not ready");

endmodule

bind neighbor_pair_filter npf_checker u_npf_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data, .cfg_ready
);
